// File: rtl/shoe_pkg.sv
package shoe_pkg;

   // Coordinate width used for the arithmetic; the port fields stay 32 bits.
   localparam int COORD_WIDTH = 32;
   localparam int XY_W        = 32;
   localparam int REQ_W       = 2 * XY_W;

   // Cross products, cross terms and the running sum.
   localparam int PROD_W  = 2 * COORD_WIDTH;
   localparam int TERM_W  = PROD_W + 1;
   localparam int SUM_W   = 64;
   localparam int WIDE_W  = SUM_W + 2;
   localparam int AEXT_W  = WIDE_W - SUM_W;
   localparam int TEXT_W  = WIDE_W - TERM_W;

   // Result fields.
   localparam int AREA_W  = 63;
   localparam int UNIT_W  = 2;
   localparam int SEL_W   = 3;
   localparam int RSP_W   = 2 * AREA_W + UNIT_W;
   localparam int USER_W  = 2;
   localparam int CSR_W   = 8;
   localparam int FRAC_W  = 16;

   typedef enum logic [UNIT_W-1:0] {
      UNIT_M2  = 2'd0,
      UNIT_ARE = 2'd1,
      UNIT_HA  = 2'd2,
      UNIT_KM2 = 2'd3
   } unit_type;

   // Automatic unit thresholds in Q.16 square metres.
   localparam logic [AREA_W-1:0] LIM_ARE = AREA_W'(64'd100 << FRAC_W);
   localparam logic [AREA_W-1:0] LIM_HA  = AREA_W'(64'd1000 << FRAC_W);
   localparam logic [AREA_W-1:0] LIM_KM2 = AREA_W'(64'd1000000 << FRAC_W);

   // Digit-serial division by an odd constant, one 12-bit digit per two stages.
   localparam int DIG_W       = 12;
   localparam int NUM_DIG     = 6;
   localparam int DIV_W       = DIG_W * NUM_DIG;
   localparam int REM_W       = 14;
   localparam int T_W         = REM_W + DIG_W;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 32;
   localparam int PRODR_W     = T_W + RECIP_W;
   localparam int SHIFT_W     = 3;

   // Queue between the front and the back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             ovf;
   } sat_sum_type;

   // One finished polygon, handed from the front to the back.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             sat;
      logic             few;
   } poly_sum_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // Adds a cross term to the sum exactly and clamps to the signed 64-bit range.
   function automatic sat_sum_type sat_add(input logic [SUM_W-1:0] acc,
                                           input logic [TERM_W-1:0] term);
      logic [WIDE_W-1:0] wide;
      sat_sum_type       res;
      wide = {{AEXT_W{acc[SUM_W-1]}}, acc} + {{TEXT_W{term[TERM_W-1]}}, term};
      if (wide[WIDE_W-1:SUM_W-1] == '0 || wide[WIDE_W-1:SUM_W-1] == '1) begin
         res.sum = wide[SUM_W-1:0];
         res.ovf = 1'b0;
      end else begin
         res.ovf = 1'b1;
         res.sum = wide[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Power-of-two part of each unit factor.
   function automatic logic [SHIFT_W-1:0] unit_shift(input unit_type unit);
      case (unit)
         UNIT_ARE: return SHIFT_W'(2);
         UNIT_HA:  return SHIFT_W'(4);
         UNIT_KM2: return SHIFT_W'(6);
         default:  return SHIFT_W'(0);
      endcase
   endfunction

   // Odd part of each unit factor: 100 = 4*25, 10000 = 16*625, 1000000 = 64*15625.
   function automatic logic [REM_W-1:0] unit_odd(input unit_type unit);
      case (unit)
         UNIT_ARE: return REM_W'(25);
         UNIT_HA:  return REM_W'(625);
         UNIT_KM2: return REM_W'(15625);
         default:  return REM_W'(1);
      endcase
   endfunction

   // floor(2^32 / odd part); the estimate it gives is low by at most one.
   function automatic logic [RECIP_W-1:0] unit_recip(input unit_type unit);
      case (unit)
         UNIT_ARE: return RECIP_W'(171798691);
         UNIT_HA:  return RECIP_W'(6871947);
         UNIT_KM2: return RECIP_W'(274877);
         default:  return RECIP_W'(0);
      endcase
   endfunction

endpackage

// File: rtl/shoe_front.sv
module shoe_front import shoe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                req_tlast,
   input  fifo_stat_type       fifo_stat,
   output logic                push_valid,
   output poly_sum_type        push_data
);

   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic                   few;
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] px;
      logic [COORD_WIDTH-1:0] py;
      logic [COORD_WIDTH-1:0] fx;
      logic [COORD_WIDTH-1:0] fy;
   } opnd_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              few;
      logic [PROD_W-1:0] p1;
      logic [PROD_W-1:0] p2;
      logic [PROD_W-1:0] p3;
      logic [PROD_W-1:0] p4;
   } prod_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              few;
      logic [TERM_W-1:0] t1;
      logic [TERM_W-1:0] t2;
   } term_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic              few;
      logic [SUM_W-1:0]  sum;
      logic [TERM_W-1:0] t2;
   } close_type;

   logic                   en;
   logic                   take;
   logic [COORD_WIDTH-1:0] cur_x;
   logic [COORD_WIDTH-1:0] cur_y;
   logic                   close_use;

   logic [COORD_WIDTH-1:0] first_x_ff, first_x_in;
   logic [COORD_WIDTH-1:0] first_y_ff, first_y_in;
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic [1:0]             seen_ff, seen_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic                   sat_ff, sat_in;

   opnd_type  s1_ff, s1_in;
   prod_type  s2_ff, s2_in;
   term_type  s3_ff, s3_in;
   close_type s4_ff, s4_in;

   sat_sum_type run_sum;
   sat_sum_type fin_sum;

   // The whole front advances together while the queue has room.
   assign en         = !fifo_stat.full;
   assign req_tready = en;
   assign take       = req_tvalid && en;

   assign cur_x = req_tdata[COORD_WIDTH-1:0];
   assign cur_y = req_tdata[XY_W +: COORD_WIDTH];

   // Vertex bookkeeping: first and previous vertex, saturating vertex count.
   always_comb begin
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      seen_in    = seen_ff;
      if (take) begin
         if (req_tlast) begin
            first_x_in = '0;
            first_y_in = '0;
            prev_x_in  = '0;
            prev_y_in  = '0;
            seen_in    = '0;
         end else begin
            if (seen_ff == 2'd0) begin
               first_x_in = cur_x;
               first_y_in = cur_y;
            end
            prev_x_in = cur_x;
            prev_y_in = cur_y;
            seen_in   = (seen_ff == 2'd3) ? seen_ff : seen_ff + 2'd1;
         end
      end
   end

   // Operands of the edge term and of the closing term; unused ones are zero.
   assign close_use = req_tlast && (seen_ff != 2'd0);

   always_comb begin
      s1_in.valid = take;
      s1_in.last  = req_tlast;
      s1_in.few   = (seen_ff < 2'd2);
      s1_in.x     = cur_x;
      s1_in.y     = cur_y;
      s1_in.px    = (seen_ff != 2'd0) ? prev_x_ff : '0;
      s1_in.py    = (seen_ff != 2'd0) ? prev_y_ff : '0;
      s1_in.fx    = close_use ? first_x_ff : '0;
      s1_in.fy    = close_use ? first_y_ff : '0;
   end

   // Four independent signed products.
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.last  = s1_ff.last;
      s2_in.few   = s1_ff.few;
      s2_in.p1    = $signed(s1_ff.px) * $signed(s1_ff.y);
      s2_in.p2    = $signed(s1_ff.py) * $signed(s1_ff.x);
      s2_in.p3    = $signed(s1_ff.x) * $signed(s1_ff.fy);
      s2_in.p4    = $signed(s1_ff.y) * $signed(s1_ff.fx);
   end

   // Edge term and closing term, exact.
   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.last  = s2_ff.last;
      s3_in.few   = s2_ff.few;
      s3_in.t1    = {s2_ff.p1[PROD_W-1], s2_ff.p1} - {s2_ff.p2[PROD_W-1], s2_ff.p2};
      s3_in.t2    = {s2_ff.p3[PROD_W-1], s2_ff.p3} - {s2_ff.p4[PROD_W-1], s2_ff.p4};
   end

   // Running sum with saturation; a polygon end hands the sum on and clears it.
   assign run_sum = sat_add(acc_ff, s3_ff.t1);

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (en && s3_ff.valid) begin
         if (s3_ff.last) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = run_sum.sum;
            sat_in = sat_ff || run_sum.ovf;
         end
      end
      s4_in.valid = s3_ff.valid && s3_ff.last;
      s4_in.sat   = sat_ff || run_sum.ovf;
      s4_in.few   = s3_ff.few;
      s4_in.sum   = run_sum.sum;
      s4_in.t2    = s3_ff.t2;
   end

   // Closing term added on its own, then the polygon goes into the queue.
   assign fin_sum        = sat_add(s4_ff.sum, s4_ff.t2);
   assign push_valid     = en && s4_ff.valid;
   assign push_data.sum  = fin_sum.sum;
   assign push_data.sat  = s4_ff.sat || fin_sum.ovf;
   assign push_data.few  = s4_ff.few;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         seen_ff     <= '0;
         acc_ff      <= '0;
         sat_ff      <= 1'b0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         seen_ff    <= seen_in;
         acc_ff     <= acc_in;
         sat_ff     <= sat_in;
         if (en) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
            s4_ff <= s4_in;
         end
      end
   end

endmodule

// File: rtl/shoe_fifo.sv
module shoe_fifo import shoe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  poly_sum_type  push_data,
   input  logic          pop,
   output poly_sum_type  pop_data,
   output fifo_stat_type fifo_stat
);

   poly_sum_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign fifo_stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign fifo_stat.empty = (count_ff == '0);

   assign do_push = push_valid && !fifo_stat.full;
   assign do_pop  = pop && !fifo_stat.empty;

   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/shoe_back.sv
module shoe_back import shoe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SEL_W-1:0]    unit_sel,
   input  fifo_stat_type       fifo_stat,
   input  poly_sum_type        pop_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic [USER_W-1:0]   rsp_tuser
);

   localparam int NST = 2 * NUM_DIG + 1;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic              few;
      logic [AREA_W-1:0] area;
   } area_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic              few;
      unit_type          unit;
      logic [AREA_W-1:0] area;
      logic [DIV_W-1:0]  v;
      logic [DIV_W-1:0]  quot;
      logic [REM_W-1:0]  rem;
      logic [T_W-1:0]    t;
      logic [DIG_W-1:0]  qe;
   } div_type;

   logic             en;
   logic [SUM_W-1:0] mag;
   unit_type         unit_pick;

   area_type b0_ff, b0_in;
   div_type  dv_ff [NST];
   div_type  dv_in [NST];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [USER_W-1:0]   rsp_user_ff, rsp_user_in;

   // The back advances as a whole whenever the output register can move.
   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && !fifo_stat.empty;

   // Magnitude and halving; short polygons give zero area.
   assign mag = pop_data.sum[SUM_W-1] ? (~pop_data.sum + 1'b1) : pop_data.sum;

   always_comb begin
      b0_in.valid = pop;
      b0_in.sat   = pop_data.sat;
      b0_in.few   = pop_data.few;
      b0_in.area  = pop_data.few ? '0 : mag[SUM_W-1:1];
   end

   // Unit choice: selector codes above km2 pick by area thresholds.
   always_comb begin
      if (!unit_sel[SEL_W-1]) begin
         unit_pick = unit_type'(unit_sel[UNIT_W-1:0]);
      end else if (b0_ff.area < LIM_ARE) begin
         unit_pick = UNIT_M2;
      end else if (b0_ff.area < LIM_HA) begin
         unit_pick = UNIT_ARE;
      end else if (b0_ff.area < LIM_KM2) begin
         unit_pick = UNIT_HA;
      end else begin
         unit_pick = UNIT_KM2;
      end
   end

   always_comb begin
      dv_in[0].valid = b0_ff.valid;
      dv_in[0].sat   = b0_ff.sat;
      dv_in[0].few   = b0_ff.few;
      dv_in[0].unit  = unit_pick;
      dv_in[0].area  = b0_ff.area;
      dv_in[0].v     = DIV_W'(b0_ff.area) >> unit_shift(unit_pick);
      dv_in[0].quot  = '0;
      dv_in[0].rem   = '0;
      dv_in[0].t     = '0;
      dv_in[0].qe    = '0;
   end

   // Long division by the odd factor, one digit per pair of stages:
   // first a reciprocal estimate, then a multiply back and one correction.
   for (genvar k = 0; k < NUM_DIG; k++) begin : g_digit
      localparam int POS = (NUM_DIG - 1 - k) * DIG_W;

      logic [PRODR_W-1:0] prod;
      logic [T_W-1:0]     qd;
      logic [T_W-1:0]     rem_w;

      assign prod = PRODR_W'({dv_ff[2*k].rem, dv_ff[2*k].v[POS +: DIG_W]})
                    * PRODR_W'(unit_recip(dv_ff[2*k].unit));

      always_comb begin
         dv_in[2*k+1]    = dv_ff[2*k];
         dv_in[2*k+1].t  = {dv_ff[2*k].rem, dv_ff[2*k].v[POS +: DIG_W]};
         dv_in[2*k+1].qe = prod[RECIP_SHIFT +: DIG_W];
      end

      assign qd    = T_W'(dv_ff[2*k+1].qe) * T_W'(unit_odd(dv_ff[2*k+1].unit));
      assign rem_w = dv_ff[2*k+1].t - qd;

      always_comb begin
         dv_in[2*k+2] = dv_ff[2*k+1];
         if (rem_w >= T_W'(unit_odd(dv_ff[2*k+1].unit))) begin
            dv_in[2*k+2].rem = REM_W'(rem_w - T_W'(unit_odd(dv_ff[2*k+1].unit)));
            dv_in[2*k+2].quot[POS +: DIG_W] = dv_ff[2*k+1].qe + 1'b1;
         end else begin
            dv_in[2*k+2].rem = REM_W'(rem_w);
            dv_in[2*k+2].quot[POS +: DIG_W] = dv_ff[2*k+1].qe;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (en) begin
         rsp_valid_in = dv_ff[NST-1].valid;
         rsp_data_in  = {dv_ff[NST-1].unit,
                         (dv_ff[NST-1].unit == UNIT_M2) ? dv_ff[NST-1].area
                                                        : dv_ff[NST-1].quot[AREA_W-1:0],
                         dv_ff[NST-1].area};
         rsp_user_in  = {dv_ff[NST-1].sat, dv_ff[NST-1].few};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NST; i++) begin
            dv_ff[i].valid <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            b0_ff <= b0_in;
            for (int i = 0; i < NST; i++) begin
               dv_ff[i] <= dv_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/polygon_shoelace_area_core.sv
// Path: after its last vertex is accepted, a polygon passes 4 front stages, the queue,
// 14 back stages and the output register. Throughput: one vertex per cycle while the queue
// has room, and one result per cycle while rsp_tready allows; the pace is set by the
// saturating accumulate in the front and the fully pipelined digit divider.
// Reset: synchronous, active high; clears the polygon state, the queue, all valid flags
// and the unit selector (square metres).
module polygon_shoelace_area_core import shoe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // x_coord [31:0], y_coord [63:32]
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // area_m2 [62:0], area_in_unit [125:63],
                                           // unit_used [127:126]
   output logic [USER_W-1:0]  rsp_tuser,   // too_few_vertices [0], overflow [1]
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [SEL_W-1:0] unit_sel_ff, unit_sel_in;
   logic             push_valid;
   poly_sum_type     push_data;
   logic             pop;
   poly_sum_type     pop_data;
   fifo_stat_type    fifo_stat;

   // Unit selector register; writes are always taken.
   assign csr_ready   = 1'b1;
   assign unit_sel_in = csr_valid ? csr_wdata[SEL_W-1:0] : unit_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_sel_ff <= '0;
      end else begin
         unit_sel_ff <= unit_sel_in;
      end
   end

   shoe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_stat  (fifo_stat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   shoe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .fifo_stat  (fifo_stat)
   );

   shoe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .unit_sel   (unit_sel_ff),
      .fifo_stat  (fifo_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/shoe_checker.sv
module shoe_checker import shoe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [RSP_W-1:0]   rsp_tdata,
   input  logic [USER_W-1:0]  rsp_tuser
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // Reset leaves no result offered.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result item offered right after reset");

   // A short polygon reports zero area in both fields.
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[2*AREA_W-1:0] == '0)
      else $error("short polygon with nonzero area");

   // In square metres the converted area equals the area.
   a_m2_same: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_W-1:2*AREA_W] == UNIT_M2
      |-> rsp_tdata[2*AREA_W-1:AREA_W] == rsp_tdata[AREA_W-1:0])
      else $error("square metre result differs from area");

   // Conversion never enlarges the area.
   a_conv_le: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2*AREA_W-1:AREA_W] <= rsp_tdata[AREA_W-1:0])
      else $error("converted area above area");

endmodule

bind polygon_shoelace_area_core shoe_checker u_shoe_checker (.*);

// File: bench/polygon_shoelace_area_core_tb.sv
`timescale 1ns / 100ps

module polygon_shoelace_area_core_tb;
   import shoe_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int TARGET_VERTICES = 1900;
   localparam int NUM_PHASES      = 8;
   localparam int SIGN_SHIFT      = 64 - COORD_WIDTH;

   // Unit selector codes; the three spare codes behave like automatic selection.
   localparam logic [SEL_W-1:0] SEL_M2       = 3'd0;
   localparam logic [SEL_W-1:0] SEL_ARE      = 3'd1;
   localparam logic [SEL_W-1:0] SEL_HA       = 3'd2;
   localparam logic [SEL_W-1:0] SEL_KM2      = 3'd3;
   localparam logic [SEL_W-1:0] SEL_AUTO     = 3'd4;
   localparam logic [SEL_W-1:0] SEL_UNUSED_5 = 3'd5;
   localparam logic [SEL_W-1:0] SEL_UNUSED_6 = 3'd6;
   localparam logic [SEL_W-1:0] SEL_UNUSED_7 = 3'd7;

   // Automatic unit boundaries in Q.16 square metres.
   localparam logic [AREA_W-1:0] ARE_FLOOR = 63'd100 << 16;
   localparam logic [AREA_W-1:0] HA_FLOOR  = 63'd1000 << 16;
   localparam logic [AREA_W-1:0] KM2_FLOOR = 63'd1000000 << 16;

   localparam logic [XY_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [XY_W-1:0] COORD_MIN = 32'h8000_0000;

   typedef struct {
      logic [AREA_W-1:0] area;
      logic [AREA_W-1:0] conv;
      unit_type          unit;
      bit                few;
      bit                ovf;
   } area_result_type;

   // Tracks the polygon in progress and holds the areas still owed by the block.
   class area_predictor;
      logic [SEL_W-1:0] unit_sel;
      longint           first_x, first_y, prev_x, prev_y;
      logic [63:0]      cross_sum;
      int               vertex_count;
      bit               saturated;
      area_result_type  expected_areas[$];
      int               mismatches;

      function new();
         unit_sel = SEL_M2;
         mismatches = 0;
         clear_polygon();
      endfunction

      function void clear_polygon();
         first_x = 0;
         first_y = 0;
         prev_x = 0;
         prev_y = 0;
         cross_sum = '0;
         vertex_count = 0;
         saturated = 0;
      endfunction

      function int pending();
         return expected_areas.size();
      endfunction

      // Sign-extends a coordinate from the block's arithmetic width.
      function longint widen(logic [XY_W-1:0] raw);
         logic [63:0] t;
         t = 64'(raw) << SIGN_SHIFT;
         return $signed(t) >>> SIGN_SHIFT;
      endfunction

      // Adds ax*by - ay*bx exactly and clamps the sum to the signed 64-bit range.
      function void add_cross(longint ax, longint ay, longint bx, longint by);
         logic signed [65:0] acc, p1, p2, wide;
         acc = 66'($signed(cross_sum));
         p1 = 66'(ax) * 66'(by);
         p2 = 66'(ay) * 66'(bx);
         wide = acc + p1 - p2;
         if (wide[65:63] == 3'b000 || wide[65:63] == 3'b111) begin
            cross_sum = wide[63:0];
         end else begin
            saturated = 1;
            cross_sum = wide[65] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
         end
      endfunction

      function void take_vertex(logic [XY_W-1:0] xr, logic [XY_W-1:0] yr, bit last);
         longint          x, y;
         logic [63:0]     mag;
         area_result_type r;
         x = widen(xr);
         y = widen(yr);
         if (vertex_count == 0) begin
            first_x = x;
            first_y = y;
         end else begin
            add_cross(prev_x, prev_y, x, y);
         end
         prev_x = x;
         prev_y = y;
         if (vertex_count < 3) vertex_count++;
         if (!last) return;

         // Closing edge back to the first vertex.
         if (vertex_count >= 2) add_cross(x, y, first_x, first_y);
         r.few = vertex_count < 3;
         mag = cross_sum[63] ? -cross_sum : cross_sum;
         r.area = r.few ? '0 : mag[63:1];
         r.ovf = saturated;

         // Unit choice: fixed by the selector, or by the area thresholds.
         if (unit_sel <= SEL_KM2) r.unit = unit_type'(unit_sel[UNIT_W-1:0]);
         else if (r.area < ARE_FLOOR) r.unit = UNIT_M2;
         else if (r.area < HA_FLOOR) r.unit = UNIT_ARE;
         else if (r.area < KM2_FLOOR) r.unit = UNIT_HA;
         else r.unit = UNIT_KM2;

         case (r.unit)
            UNIT_ARE: r.conv = r.area / 63'd100;
            UNIT_HA:  r.conv = r.area / 63'd10000;
            UNIT_KM2: r.conv = r.area / 63'd1000000;
            default:  r.conv = r.area;
         endcase
         expected_areas.push_back(r);
         clear_polygon();
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
         mismatches++;
      endtask

      task check_area(logic [RSP_W-1:0] d, logic [USER_W-1:0] u);
         area_result_type w;
         if (expected_areas.size() == 0) begin
            report_mismatch("result with no finished polygon", d[62:0], 0);
            return;
         end
         w = expected_areas.pop_front();
         if (d[62:0] !== w.area) report_mismatch("area_m2", d[62:0], w.area);
         if (d[125:63] !== w.conv) report_mismatch("area_in_unit", d[125:63], w.conv);
         if (d[127:126] !== w.unit) report_mismatch("unit_used", d[127:126], w.unit);
         if (u[0] !== w.few) report_mismatch("too_few_vertices", u[0], w.few);
         if (u[1] !== w.ovf) report_mismatch("overflow", u[1], w.ovf);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;   // x_coord [31:0], y_coord [63:32]
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;   // area_m2 [62:0], area_in_unit [125:63], unit_used [127:126]
   logic [USER_W-1:0]  rsp_tuser;   // too_few_vertices [0], overflow [1]
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_wdata;

   area_predictor      pred;
   logic [XY_W-1:0]    poly_x[$];
   logic [XY_W-1:0]    poly_y[$];
   logic [XY_W-1:0]    corner_vals[6];
   logic [SEL_W-1:0]   phase_sel[NUM_PHASES];
   int                 vertices_sent;
   int                 idle_pct;
   int                 hold_left;
   int                 stalled_cycles;

   polygon_shoelace_area_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Handshake monitor: results are checked before a new vertex is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) pred.check_area(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) pred.take_vertex(req_tdata[31:0], req_tdata[63:32],
                                                        req_tlast);
         if (csr_valid && csr_ready) pred.unit_sel = csr_wdata[SEL_W-1:0];
      end
   end

   // Result side back-pressure in bursts of random length.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_tready <= 1'b0;
         hold_left = $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic [XY_W-1:0] rand_coord(int bits);
      logic signed [XY_W-1:0] v;
      v = $urandom;
      if (bits < XY_W) v = (v <<< (XY_W - bits)) >>> (XY_W - bits);
      return v;
   endfunction

   task automatic add_vertex(logic [XY_W-1:0] x, logic [XY_W-1:0] y);
      poly_x.push_back(x);
      poly_y.push_back(y);
   endtask

   // Presents one vertex, with an occasional gap before it, and waits for acceptance.
   task automatic send_vertex(logic [XY_W-1:0] x, logic [XY_W-1:0] y, bit last);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      vertices_sent++;
   endtask

   task automatic send_polygon();
      int i;
      for (i = 0; i < poly_x.size(); i++)
         send_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
      poly_x.delete();
      poly_y.delete();
   endtask

   // Drops valid and waits until every area has come back and the pipeline is empty.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pred.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_unit(logic [SEL_W-1:0] sel);
      logic [CSR_W-1:0] word;
      word = CSR_W'($urandom);
      word[SEL_W-1:0] = sel;
      csr_valid <= 1'b1;
      csr_wdata <= word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random polygon drawn from a mix of shapes.
   task automatic random_polygon();
      int               kind, n, bits, base;
      logic [XY_W-1:0]  w, h, x0, y0;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         n = $urandom_range(3, 8);
         bits = $urandom_range(4, 32);
         repeat (n) add_vertex(rand_coord(bits), rand_coord(bits));
      end else if (kind < 60) begin
         // Rectangles whose area mostly sits on or next to an automatic unit boundary.
         case ($urandom_range(0, 2))
            0: base = 25600;
            1: base = 256000;
            default: base = 256000000;
         endcase
         w = 256;
         h = base + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 3) == 0) begin
            w = $urandom_range(1, 32768);
            h = $urandom_range(1, 32768);
         end
         x0 = rand_coord(24);
         y0 = rand_coord(24);
         if ($urandom_range(0, 1)) begin
            add_vertex(x0, y0);
            add_vertex(x0 + w, y0);
            add_vertex(x0 + w, y0 + h);
            add_vertex(x0, y0 + h);
         end else begin
            add_vertex(x0, y0 + h);
            add_vertex(x0 + w, y0 + h);
            add_vertex(x0 + w, y0);
            add_vertex(x0, y0);
         end
      end else if (kind < 70) begin
         n = $urandom_range(3, 6);
         repeat (n) add_vertex(rand_coord(32), rand_coord(32));
      end else if (kind < 80) begin
         n = $urandom_range(1, 2);
         bits = $urandom_range(4, 32);
         repeat (n) add_vertex(rand_coord(bits), rand_coord(bits));
      end else if (kind < 90) begin
         n = $urandom_range(9, 20);
         bits = $urandom_range(4, 20);
         repeat (n) add_vertex(rand_coord(bits), rand_coord(bits));
      end else begin
         n = $urandom_range(3, 6);
         repeat (n) add_vertex(corner_vals[$urandom_range(0, 5)],
                               corner_vals[$urandom_range(0, 5)]);
      end
      send_polygon();
   endtask

   initial begin
      int p;
      pred = new();
      corner_vals = '{COORD_MAX, COORD_MIN, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0001};
      phase_sel = '{SEL_AUTO, SEL_ARE, SEL_HA, SEL_KM2, SEL_UNUSED_5, SEL_M2,
                    SEL_UNUSED_6, SEL_UNUSED_7};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = '0;
      vertices_sent = 0;
      idle_pct = 0;
      hold_left = 0;
      stalled_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed polygons at the reset unit: short ones, a 10 m square,
      // saturation both ways, the full coordinate square and a flat triangle.
      add_vertex(COORD_MAX, COORD_MIN);
      send_polygon();
      add_vertex(32'd1, 32'd2);
      add_vertex(32'd3, 32'd4);
      send_polygon();
      add_vertex(32'd0, 32'd0);
      add_vertex(32'd2560, 32'd0);
      add_vertex(32'd2560, 32'd2560);
      add_vertex(32'd0, 32'd2560);
      send_polygon();
      add_vertex(COORD_MAX, 32'd0);
      add_vertex(32'd0, COORD_MAX);
      add_vertex(COORD_MIN, COORD_MIN);
      send_polygon();
      add_vertex(COORD_MIN, COORD_MIN);
      add_vertex(32'd0, COORD_MAX);
      add_vertex(COORD_MAX, 32'd0);
      send_polygon();
      add_vertex(COORD_MIN, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MIN);
      add_vertex(COORD_MAX, COORD_MAX);
      add_vertex(COORD_MIN, COORD_MAX);
      send_polygon();
      add_vertex(32'hFFFF_FF00, 32'hFFFF_FF00);
      add_vertex(32'd256, 32'd256);
      add_vertex(32'd512, 32'd512);
      send_polygon();

      // Random phases, one unit setting each; the last phase runs without idling.
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_unit(phase_sel[p]);
         if (p == NUM_PHASES - 1) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 35;
            endcase
         end
         while (vertices_sent < (p + 1) * TARGET_VERTICES / NUM_PHASES) random_polygon();
      end

      wait_idle();
      if (pred.mismatches == 0 && pred.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
